// ----- src/shbs_pkg.sv -----
// Package for the SHA-256 byte stream hasher: queue entry type, back-end state
// enum, round constants, initial hash values and a rotate-right helper.
// No dependencies.
`timescale 1ns / 1ps

package shbs_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } beat_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ROUND,
        BK_FOLD,
        BK_EMIT
    } bk_state_t;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        begin
            case (t)
                6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
                6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
                6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
                6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
                6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] h;
        begin
            case (i)
                3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
            endcase
            return h;
        end
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        begin
            return (x >> n) | (x << (32 - n));
        end
    endfunction

endpackage

// ----- src/sha256_byte_stream_hasher.sv -----
// Top level of the SHA-256 byte stream hasher: front queue and back end.
// Depends on shbs_pkg, shbs_front and shbs_back.
`timescale 1ns / 1ps

// Bytes go in one per beat into a short queue; a byte that does not complete a
// block is taken by the back end while it is idle. A completed 64-byte block
// goes through load, 64 rounds one per cycle in the single round unit, and fold;
// an end beat costs one or two such blocks and then eight output beats, word 0
// first, last_word on word 7. The queue lets bytes arrive while a block runs.
module sha256_byte_stream_hasher #(
    parameter int QUEUE_DEPTH = shbs_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    shbs_pkg::beat_t in_beat, q_beat;
    logic            q_valid, q_ready;

    assign in_beat.data_byte      = data_byte;
    assign in_beat.has_byte       = has_byte;
    assign in_beat.end_of_message = end_of_message;

    shbs_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_beat(in_beat),
        .q_valid(q_valid), .q_ready(q_ready), .q_beat(q_beat)
    );

    shbs_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_beat(q_beat),
        .out_valid(out_valid), .out_ready(out_ready),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
    );

    a_last_on_seven: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word out of step with word_index");

    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_word) |=> (out_valid &&
            word_index == $past(word_index) + 3'd1))
        else $error("digest words not in order");

    a_no_take_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !q_ready)
        else $error("back end took a beat while emitting");
endmodule

// ----- src/shbs_front.sv -----
// Front end: takes input beats into a short queue and drops beats that carry
// neither a byte nor an end mark. Depends on shbs_pkg.
`timescale 1ns / 1ps

module shbs_front #(
    parameter int DEPTH = shbs_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  shbs_pkg::beat_t   in_beat,
    output logic              q_valid,
    input  logic              q_ready,
    output shbs_pkg::beat_t   q_beat
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    shbs_pkg::beat_t mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          push, pop;

    assign in_ready = (cnt_reg != AW'(0) + (AW+1)'(DEPTH));
    assign push     = in_valid && in_ready && (in_beat.has_byte || in_beat.end_of_message);
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_beat   = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? ((wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = pop ? ((rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_beat;
        end
    end
endmodule

// ----- src/shbs_back.sv -----
// Back end: packs bytes into a 16-word block, pads, runs the 64 rounds one a
// cycle, folds into the chaining value and emits the digest. Depends on shbs_pkg.
`timescale 1ns / 1ps

module shbs_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  shbs_pkg::beat_t q_beat,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [31:0]     digest_word,
    output logic [2:0]      word_index,
    output logic            last_word
);
    shbs_pkg::bk_state_t state_reg, state_next;

    logic [31:0] w_reg [16];          // block words, then rolling schedule
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [5:0]  t_reg;
    logic [2:0]  idx_reg;
    logic        pad_reg;             // final block pending after this one
    logic        fin_reg;             // this block ends the message

    logic        take;
    logic [5:0]  fill_plus;
    logic [31:0] wt, s0w, s1w, t1, t2, bs0, bs1, ch, maj;
    logic [31:0] new_w [16];
    logic [31:0] pad_w [16];
    logic [3:0]  wi;
    logic [5:0]  pf;

    function automatic logic [31:0] bits_reg_n_hi(input logic [63:0] b, input logic hb);
        logic [63:0] n;
        begin
            n = b + (hb ? 64'd8 : 64'd0);
            return n[63:32];
        end
    endfunction

    function automatic logic [31:0] bits_reg_n_lo(input logic [63:0] b, input logic hb);
        logic [63:0] n;
        begin
            n = b + (hb ? 64'd8 : 64'd0);
            return n[31:0];
        end
    endfunction

    assign take      = (state_reg == shbs_pkg::BK_IDLE) && q_valid;
    assign q_ready   = (state_reg == shbs_pkg::BK_IDLE);
    assign out_valid = (state_reg == shbs_pkg::BK_EMIT);
    assign digest_word = h_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd7);
    assign fill_plus   = fill_reg + 6'(q_beat.has_byte);

    // byte insert, then padding of the block as it stands after that insert
    always_comb
    begin
        wi = fill_reg[5:2];
        for (int i = 0; i < 16; i++)
        begin
            new_w[i] = w_reg[i];
        end
        if (q_beat.has_byte)
        begin
            case (fill_reg[1:0])
                2'd0: new_w[wi][31:24] = q_beat.data_byte;
                2'd1: new_w[wi][23:16] = q_beat.data_byte;
                2'd2: new_w[wi][15:8]  = q_beat.data_byte;
                default: new_w[wi][7:0] = q_beat.data_byte;
            endcase
        end
        pf = fill_plus;
        for (int i = 0; i < 16; i++)
        begin
            pad_w[i] = new_w[i];
            for (int b = 0; b < 4; b++)
            begin
                if (6'(4 * i + b) == pf)
                begin
                    pad_w[i][31-8*b -: 8] = 8'h80;
                end
                else if (6'(4 * i + b) > pf)
                begin
                    pad_w[i][31-8*b -: 8] = 8'h00;
                end
            end
        end
        // a full block from this byte is compressed as it is
        if (pf == 6'd0 && q_beat.has_byte)
        begin
            for (int i = 0; i < 16; i++)
            begin
                pad_w[i] = new_w[i];
            end
        end
    end

    always_comb
    begin
        if (t_reg < 6'd16)
        begin
            s1w = '0;
            s0w = '0;
            wt  = w_reg[t_reg[3:0]];
        end
        else
        begin
            s1w = shbs_pkg::rotr(w_reg[t_reg[3:0] - 4'd2], 17)
                ^ shbs_pkg::rotr(w_reg[t_reg[3:0] - 4'd2], 19)
                ^ (w_reg[t_reg[3:0] - 4'd2] >> 10);
            s0w = shbs_pkg::rotr(w_reg[t_reg[3:0] - 4'd15], 7)
                ^ shbs_pkg::rotr(w_reg[t_reg[3:0] - 4'd15], 18)
                ^ (w_reg[t_reg[3:0] - 4'd15] >> 3);
            wt = s1w + w_reg[t_reg[3:0] - 4'd7] + s0w + w_reg[t_reg[3:0]];
        end
        bs1 = shbs_pkg::rotr(v_reg[4], 6) ^ shbs_pkg::rotr(v_reg[4], 11)
            ^ shbs_pkg::rotr(v_reg[4], 25);
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1  = v_reg[7] + bs1 + ch + shbs_pkg::round_k(t_reg) + wt;
        bs0 = shbs_pkg::rotr(v_reg[0], 2) ^ shbs_pkg::rotr(v_reg[0], 13)
            ^ shbs_pkg::rotr(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2  = bs0 + maj;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            shbs_pkg::BK_IDLE:
            begin
                if (take && (q_beat.end_of_message || fill_plus == 6'd0))
                begin
                    state_next = shbs_pkg::BK_ROUND;
                end
            end
            shbs_pkg::BK_ROUND:
            begin
                if (t_reg == 6'd63)
                begin
                    state_next = shbs_pkg::BK_FOLD;
                end
            end
            shbs_pkg::BK_FOLD:
            begin
                if (pad_reg)
                begin
                    state_next = shbs_pkg::BK_ROUND;
                end
                else if (fin_reg)
                begin
                    state_next = shbs_pkg::BK_EMIT;
                end
                else
                begin
                    state_next = shbs_pkg::BK_IDLE;
                end
            end
            shbs_pkg::BK_EMIT:
            begin
                if (out_ready && idx_reg == 3'd7)
                begin
                    state_next = shbs_pkg::BK_IDLE;
                end
            end
            default: state_next = shbs_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shbs_pkg::BK_IDLE;
            fill_reg  <= '0;
            bits_reg  <= '0;
            t_reg     <= '0;
            idx_reg   <= '0;
            pad_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= shbs_pkg::init_hash(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                shbs_pkg::BK_IDLE:
                begin
                    t_reg <= '0;
                    if (take)
                    begin
                        fill_reg <= fill_plus;
                        bits_reg <= bits_reg + (q_beat.has_byte ? 64'd8 : 64'd0);
                        fin_reg  <= q_beat.end_of_message;
                        // full block from this byte and end: pad goes in an extra block
                        // also when the pad spills past byte 55
                        pad_reg  <= q_beat.end_of_message &&
                                    ((fill_plus == 6'd0 && q_beat.has_byte) ||
                                     fill_plus >= 6'd56);
                    end
                end
                shbs_pkg::BK_ROUND:
                begin
                    t_reg <= t_reg + 6'd1;
                end
                shbs_pkg::BK_FOLD:
                begin
                    t_reg <= '0;
                    pad_reg <= 1'b0;
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                end
                shbs_pkg::BK_EMIT:
                begin
                    if (out_ready)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            fill_reg <= '0;
                            bits_reg <= '0;
                            fin_reg  <= 1'b0;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= shbs_pkg::init_hash(3'(i));
                            end
                        end
                    end
                end
                default: t_reg <= '0;
            endcase
        end
    end

    // payload: block words and working variables
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= new_w[i];
            end
            if (q_beat.end_of_message && !(fill_plus == 6'd0 && q_beat.has_byte)
                && fill_plus < 6'd56)
            begin
                for (int i = 0; i < 14; i++)
                begin
                    w_reg[i] <= pad_w[i];
                end
                w_reg[14] <= bits_reg_n_hi(bits_reg, q_beat.has_byte);
                w_reg[15] <= bits_reg_n_lo(bits_reg, q_beat.has_byte);
            end
            else if (q_beat.end_of_message && !(fill_plus == 6'd0 && q_beat.has_byte))
            begin
                for (int i = 0; i < 16; i++)
                begin
                    w_reg[i] <= pad_w[i];
                end
            end
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (state_reg == shbs_pkg::BK_ROUND)
        begin
            w_reg[t_reg[3:0]] <= wt;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        else if (state_reg == shbs_pkg::BK_FOLD && pad_reg)
        begin
            // extra block: pad byte only if the full block had no room for it
            for (int i = 0; i < 14; i++)
            begin
                w_reg[i] <= (i == 0 && fill_reg == 6'd0) ? 32'h80000000 : 32'h0;
            end
            w_reg[14] <= bits_reg[63:32];
            w_reg[15] <= bits_reg[31:0];
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end
endmodule
